@@ rtl/pomodoro_phase_timer_top_defines.svh @@
// Assertion macros shared by the pomodoro phase timer RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef POMODORO_PHASE_TIMER_TOP_DEFINES_SVH
`define POMODORO_PHASE_TIMER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ppt_pkg.sv @@
// Types, codes and constants of the pomodoro phase timer.
// No dependencies; used by the interfaces and all modules.
package ppt_pkg;

	localparam int MAX_BLOCKS = 8;
	localparam int CNT_W      = $clog2(MAX_BLOCKS);
	localparam int EVERY_W    = CNT_W + 1;

	localparam int SEC_W      = 16;
	localparam int MS_W       = 10;
	localparam int MODE_W     = 2;
	localparam int CMD_W      = 3;
	localparam int BLK_W      = 3;
	localparam int EVCFG_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [MS_W-1:0]  MS_LAST     = MS_W'(999);
	localparam logic [SEC_W-1:0] MIN_PHASE   = SEC_W'(60);
	localparam logic [SEC_W-1:0] EXTEND_SECS = SEC_W'(300);
	localparam logic [SEC_W-1:0] SEC_MAX     = '1;

	localparam logic [MODE_W-1:0] MODE_FOCUS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SHORT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LONG  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WORK_SECS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_SECS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_SECS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_EVERY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_START = 3'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_TOGGLE = 3'd1,
		CMD_SKIP   = 3'd2,
		CMD_RESET  = 3'd3,
		CMD_EXTEND = 3'd4,
		CMD_SELECT = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SEC_W-1:0]  secs;
		logic [MS_W-1:0]   ms;
		logic [SEC_W-1:0]  length;
		logic [CNT_W-1:0]  count;
		logic              run;
	} timer_state_t;

	typedef struct packed {
		logic [SEC_W-1:0]   work_secs;
		logic [SEC_W-1:0]   short_secs;
		logic [SEC_W-1:0]   long_secs;
		logic [EVCFG_W-1:0] long_every;
		logic               auto_start;
	} timer_cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] phase_mode;
		logic [SEC_W-1:0]  seconds_left;
		logic [SEC_W-1:0]  phase_length;
		logic [BLK_W-1:0]  blocks_in_cycle;
		logic              is_running;
		logic              phase_ended;
		logic              block_completed;
		logic [SEC_W-1:0]  focus_credit;
		logic              went_long;
	} timer_result_t;

endpackage

@@ rtl/ppt_item_if.sv @@
// Input channel of the pomodoro phase timer: one command beat.
// Depends on ppt_pkg.
interface ppt_item_if;
	import ppt_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [MODE_W-1:0]  mode_sel;

	modport source (output valid, output cmd, output mode_sel, input ready);
	modport sink   (input valid, input cmd, input mode_sel, output ready);
endinterface

@@ rtl/ppt_result_if.sv @@
// Result channel of the pomodoro phase timer: one status beat per command.
// Depends on ppt_pkg.
interface ppt_result_if;
	import ppt_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  phase_mode;
	logic [SEC_W-1:0]   seconds_left;
	logic [SEC_W-1:0]   phase_length;
	logic [BLK_W-1:0]   blocks_in_cycle;
	logic               is_running;
	logic               phase_ended;
	logic               block_completed;
	logic [SEC_W-1:0]   focus_credit;
	logic               went_long;

	modport source (
		output valid, output phase_mode, output seconds_left, output phase_length,
		output blocks_in_cycle, output is_running, output phase_ended,
		output block_completed, output focus_credit, output went_long,
		input ready
	);
	modport sink (
		input valid, input phase_mode, input seconds_left, input phase_length,
		input blocks_in_cycle, input is_running, input phase_ended,
		input block_completed, input focus_credit, input went_long,
		output ready
	);
endinterface

@@ rtl/ppt_step.sv @@
// Next-state and result logic of the pomodoro phase timer for one command.
// Depends on ppt_pkg.
module ppt_step (
	input  ppt_pkg::timer_state_t       st,
	input  ppt_pkg::timer_cfg_t         cfg,
	input  logic [ppt_pkg::CMD_W-1:0]   cmd,
	input  logic [ppt_pkg::MODE_W-1:0]  mode_sel,
	output ppt_pkg::timer_state_t       nxt,
	output ppt_pkg::timer_result_t      res
);
	import ppt_pkg::*;

	function automatic logic [SEC_W-1:0] phase_len(input logic [MODE_W-1:0] m,
	                                               input timer_cfg_t c);
		logic [SEC_W-1:0] len;
		case (m)
			MODE_SHORT: len = c.short_secs;
			MODE_LONG:  len = c.long_secs;
			default:    len = c.work_secs;
		endcase
		return (len < MIN_PHASE) ? MIN_PHASE : len;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] cnt,
	                                                 input logic [EVERY_W-1:0] ev);
		logic [EVERY_W-1:0] lim;
		lim = ev - 1'b1;
		return ({1'b0, cnt} >= ev) ? lim[CNT_W-1:0] : cnt;
	endfunction

	logic [EVERY_W-1:0] eff_every;
	logic [SEC_W-1:0]   elapsed;
	logic [CNT_W:0]     cnt_inc;
	logic [SEC_W:0]     secs_ext;
	logic [SEC_W:0]     len_ext;
	logic               end_ev;
	logic               natural;
	logic [MODE_W-1:0]  load_mode;
	logic               load_ev;

	// long_every clamped to 1..MAX_BLOCKS
	always_comb begin
		if (cfg.long_every == '0) begin
			eff_every = EVERY_W'(1);
		end else if (int'(cfg.long_every) > MAX_BLOCKS) begin
			eff_every = EVERY_W'(MAX_BLOCKS);
		end else begin
			eff_every = EVERY_W'(cfg.long_every);
		end
	end

	assign elapsed  = (st.length > st.secs) ? (st.length - st.secs) : '0;
	assign cnt_inc  = {1'b0, st.count} + 1'b1;
	assign secs_ext = {1'b0, st.secs} + {1'b0, EXTEND_SECS};
	assign len_ext  = {1'b0, st.length} + {1'b0, EXTEND_SECS};

	always_comb begin
		nxt       = st;
		res       = '0;
		end_ev    = 1'b0;
		natural   = 1'b0;
		load_ev   = 1'b0;
		load_mode = MODE_FOCUS;

		unique case (cmd_t'(cmd))
			CMD_TICK: begin
				if (st.run) begin
					if (st.secs != '0) begin
						if (st.ms >= MS_LAST) begin
							nxt.ms   = '0;
							nxt.secs = st.secs - 1'b1;
						end else begin
							nxt.ms = st.ms + 1'b1;
						end
					end
					if (nxt.secs == '0) begin
						end_ev  = 1'b1;
						natural = 1'b1;
					end
				end
			end
			CMD_TOGGLE: begin
				nxt.ms  = '0;
				nxt.run = !st.run;
			end
			CMD_SKIP: begin
				nxt.run = 1'b0;
				end_ev  = 1'b1;
			end
			CMD_RESET: begin
				nxt.secs = st.length;
				nxt.ms   = '0;
			end
			CMD_EXTEND: begin
				nxt.secs   = secs_ext[SEC_W] ? SEC_MAX : secs_ext[SEC_W-1:0];
				nxt.length = len_ext[SEC_W] ? SEC_MAX : len_ext[SEC_W-1:0];
			end
			CMD_SELECT: begin
				if (mode_sel != MODE_NONE && mode_sel != st.mode) begin
					nxt.run   = 1'b0;
					load_ev   = 1'b1;
					load_mode = mode_sel;
				end
			end
			default: ;
		endcase

		// phase end: credit, block count, pick next phase
		if (end_ev) begin
			res.phase_ended = 1'b1;
			if (st.mode == MODE_FOCUS) begin
				if (natural) begin
					res.block_completed = 1'b1;
					res.focus_credit    = st.length;
				end else if (elapsed >= MIN_PHASE) begin
					res.focus_credit = elapsed;
				end
				if (cnt_inc >= eff_every) begin
					nxt.count     = '0;
					load_mode     = MODE_LONG;
					res.went_long = 1'b1;
				end else begin
					nxt.count = cnt_inc[CNT_W-1:0];
					load_mode = MODE_SHORT;
				end
			end else begin
				load_mode = MODE_FOCUS;
			end
			load_ev = 1'b1;
		end

		if (load_ev) begin
			nxt.mode   = load_mode;
			nxt.count  = clamp_count(nxt.count, eff_every);
			nxt.length = phase_len(load_mode, cfg);
			nxt.secs   = phase_len(load_mode, cfg);
			nxt.ms     = '0;
		end

		if (end_ev) begin
			nxt.run = cfg.auto_start;
		end

		res.phase_mode      = nxt.mode;
		res.seconds_left    = nxt.secs;
		res.phase_length    = nxt.length;
		res.blocks_in_cycle = BLK_W'(nxt.count);
		res.is_running      = nxt.run;
	end
endmodule

@@ rtl/pomodoro_phase_timer_top.sv @@
// Pomodoro phase timer: work / short break / long break countdown sequencer.
// Each command beat on item (1 ms tick, start/pause, skip, reset, extend by 300 s,
// select mode) produces exactly one status beat on result, in the cycle after it is
// taken. One command is taken per clock: the timer state and the result register
// update together, and item.ready stays high while the result register is empty
// or is being drained in the same cycle, so a stall on result holds one beat and
// then back-pressures item. Configuration writes (work/short/long lengths,
// long_every, auto_start) land through cfg_we/cfg_idx/cfg_wdata and take effect
// on the next phase load; write them only while no beat is in flight. There is no
// memory and no clearing pass after reset. Depends on ppt_pkg, ppt_item_if,
// ppt_result_if, ppt_step and the defines header.
`include "pomodoro_phase_timer_top_defines.svh"

module pomodoro_phase_timer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ppt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	ppt_item_if.sink                         item,
	ppt_result_if.source                     result
);
	import ppt_pkg::*;

	timer_cfg_t    cfg_q;
	timer_state_t  st_q;
	timer_state_t  st_nxt;
	timer_result_t res_nxt;
	timer_result_t res_q;
	logic          out_valid_q;
	logic          take;
	logic          long_brk_ok;

	// result register frees itself when drained, so intake never waits a bubble
	assign item.ready = !out_valid_q || result.ready;
	assign take       = item.valid && item.ready;

	ppt_step u_step (
		.st       (st_q),
		.cfg      (cfg_q),
		.cmd      (item.cmd),
		.mode_sel (item.mode_sel),
		.nxt      (st_nxt),
		.res      (res_nxt)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.work_secs  <= SEC_W'(1500);
			cfg_q.short_secs <= SEC_W'(300);
			cfg_q.long_secs  <= SEC_W'(900);
			cfg_q.long_every <= EVCFG_W'(4);
			cfg_q.auto_start <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WORK_SECS:  cfg_q.work_secs  <= cfg_wdata[SEC_W-1:0];
				REG_SHORT_SECS: cfg_q.short_secs <= cfg_wdata[SEC_W-1:0];
				REG_LONG_SECS:  cfg_q.long_secs  <= cfg_wdata[SEC_W-1:0];
				REG_LONG_EVERY: cfg_q.long_every <= cfg_wdata[EVCFG_W-1:0];
				REG_AUTO_START: cfg_q.auto_start <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// timer state: work phase, full length, paused
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode   <= MODE_FOCUS;
			st_q.secs   <= SEC_W'(1500);
			st_q.ms     <= '0;
			st_q.length <= SEC_W'(1500);
			st_q.count  <= '0;
			st_q.run    <= 1'b0;
		end else if (take) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.phase_mode      = res_q.phase_mode;
	assign result.seconds_left    = res_q.seconds_left;
	assign result.phase_length    = res_q.phase_length;
	assign result.blocks_in_cycle = res_q.blocks_in_cycle;
	assign result.is_running      = res_q.is_running;
	assign result.phase_ended     = res_q.phase_ended;
	assign result.block_completed = res_q.block_completed;
	assign result.focus_credit    = res_q.focus_credit;
	assign result.went_long       = res_q.went_long;

	// a long-break beat shows the long phase, a cleared count and a phase end
	assign long_brk_ok = result.phase_mode == MODE_LONG && result.blocks_in_cycle == '0 &&
		result.phase_ended;

	`PPT_ASSERT_NEXT(a_take_fills_out, take, out_valid_q, "accepted beat left no result")
	`PPT_ASSERT_NOW(a_len_floor, 1'b1, st_q.length >= MIN_PHASE, "phase length below minimum")
	`PPT_ASSERT_NOW(a_secs_le_len, 1'b1, st_q.secs <= st_q.length, "remaining exceeds length")
	`PPT_ASSERT_NOW(a_ms_range, 1'b1, st_q.ms <= MS_LAST, "millisecond count out of range")
	`PPT_ASSERT_NOW(a_long_result, result.valid && result.went_long, long_brk_ok, "bad long break")
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for pomodoro_phase_timer_top: a command table, a tick run and
// random command streams, with every status beat checked against an in-bench timer predictor.
// Depends on ppt_pkg, ppt_item_if, ppt_result_if and the RTL of the timer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppt_pkg::*;

	// Commands the block must ignore.
	localparam logic [CMD_W-1:0] CMD_NOP6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_NOP7 = 3'd7;

	// Cycles without any beat before the run is declared hung. The longest legal quiet
	// stretch is the deliberate receiver hold-off below; random stalls are far shorter.
	localparam int HANG_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RAND_PHASES  = 8;
	localparam int RAND_PER_PHS = 90;

	// One row of the directed table: a full register setting, or one command beat with
	// an optional hand-written expected status.
	typedef struct {
		bit            is_cfg;
		timer_cfg_t    cfg;
		logic [CMD_W-1:0]  cmd;
		logic [MODE_W-1:0] sel;
		bit            has_lit;
		timer_result_t lit;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ppt_item_if   cmd_ch ();
	ppt_result_if status_ch ();

	pomodoro_phase_timer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (cmd_ch),
		.result    (status_ch)
	);

	// Predictor copy of the timer registers and state.
	timer_cfg_t        cfg_now;
	logic [MODE_W-1:0] p_mode;
	logic [SEC_W-1:0]  p_secs;
	logic [SEC_W-1:0]  p_len;
	logic [MS_W-1:0]   p_ms;
	logic [3:0]        p_cnt;   // one bit wider: briefly reaches long_every before wrapping
	bit                p_run;

	timer_result_t status_q[$];   // expected status beats, oldest first
	int  bad = 0;
	int  gap_pct = 0;             // chance per cycle that the sender sits idle
	int  stall_pct = 0;           // chance per cycle that the receiver drops ready
	bit  hold_req = 1'b0;         // asks the receiver for one long hold-off
	plan_row_t plan_q[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// long_every as the block uses it: clamped to 1..MAX_BLOCKS.
	function automatic int unsigned every_used();
		int unsigned e;
		e = cfg_now.long_every;
		if (e < 1) e = 1;
		if (e > MAX_BLOCKS) e = MAX_BLOCKS;
		return e;
	endfunction

	function automatic void enter_phase(logic [MODE_W-1:0] m);
		int unsigned e;
		logic [SEC_W-1:0] len;
		e = every_used();
		p_mode = m;
		if (p_cnt >= e) p_cnt = 4'(e - 1);
		if (m == MODE_SHORT) len = cfg_now.short_secs;
		else if (m == MODE_LONG) len = cfg_now.long_secs;
		else len = cfg_now.work_secs;
		if (len < MIN_PHASE) len = MIN_PHASE;
		p_len  = len;
		p_secs = len;
		p_ms   = '0;
	endfunction

	// End of the current phase, by running out (natural) or by a skip.
	function automatic void close_phase(bit natural, inout timer_result_t r);
		int unsigned elapsed;
		logic [MODE_W-1:0] nxt;
		elapsed = (p_len > p_secs) ? int'(p_len) - int'(p_secs) : 0;
		nxt = MODE_SHORT;
		p_run = 1'b0;
		r.phase_ended = 1'b1;
		if (p_mode == MODE_FOCUS) begin
			if (natural) begin
				r.block_completed = 1'b1;
				r.focus_credit    = p_len;
			end else if (elapsed >= MIN_PHASE) begin
				r.focus_credit = SEC_W'(elapsed);
			end
			p_cnt = p_cnt + 1'b1;
			if (p_cnt >= every_used()) begin
				p_cnt = '0;
				nxt = MODE_LONG;
				r.went_long = 1'b1;
			end
			enter_phase(nxt);
		end else begin
			enter_phase(MODE_FOCUS);
		end
		if (cfg_now.auto_start) begin
			p_run = 1'b1;
			p_ms  = '0;
		end
	endfunction

	// Applies one command to the predictor state; returns the status beat it causes.
	function automatic timer_result_t next_status(logic [CMD_W-1:0] c, logic [MODE_W-1:0] s);
		timer_result_t r;
		int unsigned   sum;
		r = '0;
		case (c)
			CMD_TICK: begin
				if (p_run) begin
					if (p_secs != 0) begin
						if (p_ms == MS_LAST) begin
							p_ms   = '0;
							p_secs = p_secs - 1'b1;
						end else begin
							p_ms = p_ms + 1'b1;
						end
					end
					if (p_secs == 0) close_phase(1'b1, r);
				end
			end
			CMD_TOGGLE: begin
				p_ms  = '0;
				p_run = !p_run;
			end
			CMD_SKIP: begin
				p_run = 1'b0;
				close_phase(1'b0, r);
			end
			CMD_RESET: begin
				p_secs = p_len;
				p_ms   = '0;
			end
			CMD_EXTEND: begin
				sum = int'(p_secs) + int'(EXTEND_SECS);
				p_secs = (sum > int'(SEC_MAX)) ? SEC_MAX : SEC_W'(sum);
				sum = int'(p_len) + int'(EXTEND_SECS);
				p_len = (sum > int'(SEC_MAX)) ? SEC_MAX : SEC_W'(sum);
			end
			CMD_SELECT: begin
				if (s != MODE_NONE && s != p_mode) begin
					p_run = 1'b0;
					enter_phase(s);
				end
			end
			default: ;
		endcase
		r.phase_mode      = p_mode;
		r.seconds_left    = p_secs;
		r.phase_length    = p_len;
		r.blocks_in_cycle = p_cnt[BLK_W-1:0];
		r.is_running      = p_run;
		return r;
	endfunction

	// ---------------------------------------------------------------- directed table

	function automatic timer_result_t st(logic [MODE_W-1:0] m, logic [SEC_W-1:0] secs,
			logic [SEC_W-1:0] len, logic [BLK_W-1:0] blk, bit run, bit ended, bit wl);
		timer_result_t r;
		r = '0;
		r.phase_mode      = m;
		r.seconds_left    = secs;
		r.phase_length    = len;
		r.blocks_in_cycle = blk;
		r.is_running      = run;
		r.phase_ended     = ended;
		r.went_long       = wl;
		return r;
	endfunction

	function automatic void lit_row(logic [CMD_W-1:0] c, logic [MODE_W-1:0] s,
			timer_result_t r);
		plan_row_t row;
		row = '{default: '0};
		row.cmd = c;
		row.sel = s;
		row.has_lit = 1'b1;
		row.lit = r;
		plan_q.push_back(row);
	endfunction

	function automatic void step_row(logic [CMD_W-1:0] c, logic [MODE_W-1:0] s);
		plan_row_t row;
		row = '{default: '0};
		row.cmd = c;
		row.sel = s;
		plan_q.push_back(row);
	endfunction

	function automatic void cfg_row(logic [SEC_W-1:0] w, logic [SEC_W-1:0] sh,
			logic [SEC_W-1:0] lg, logic [EVCFG_W-1:0] every, logic autos);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.cfg = '{work_secs: w, short_secs: sh, long_secs: lg, long_every: every,
			auto_start: autos};
		plan_q.push_back(row);
	endfunction

	function automatic void build_plan();
		// Defaults after reset: work 1500, short 300, long 900, every 4, no auto start.
		lit_row(CMD_TICK,   MODE_FOCUS, st(MODE_FOCUS, 1500, 1500, 0, 0, 0, 0)); // paused tick
		lit_row(CMD_NOP6,   MODE_LONG,  st(MODE_FOCUS, 1500, 1500, 0, 0, 0, 0));
		lit_row(CMD_NOP7,   MODE_NONE,  st(MODE_FOCUS, 1500, 1500, 0, 0, 0, 0));
		lit_row(CMD_EXTEND, MODE_FOCUS, st(MODE_FOCUS, 1800, 1800, 0, 0, 0, 0));
		lit_row(CMD_RESET,  MODE_FOCUS, st(MODE_FOCUS, 1800, 1800, 0, 0, 0, 0));
		lit_row(CMD_SELECT, MODE_NONE,  st(MODE_FOCUS, 1800, 1800, 0, 0, 0, 0)); // no mode
		lit_row(CMD_SELECT, MODE_FOCUS, st(MODE_FOCUS, 1800, 1800, 0, 0, 0, 0)); // same mode
		// skip with nothing elapsed: block counted, no credit
		lit_row(CMD_SKIP,   MODE_FOCUS, st(MODE_SHORT, 300, 300, 1, 0, 1, 0));
		lit_row(CMD_SKIP,   MODE_FOCUS, st(MODE_FOCUS, 1500, 1500, 1, 0, 1, 0));
		lit_row(CMD_TOGGLE, MODE_FOCUS, st(MODE_FOCUS, 1500, 1500, 1, 1, 0, 0));
		lit_row(CMD_TICK,   MODE_NONE,  st(MODE_FOCUS, 1500, 1500, 1, 1, 0, 0));
		lit_row(CMD_TOGGLE, MODE_FOCUS, st(MODE_FOCUS, 1500, 1500, 1, 0, 0, 0));
		lit_row(CMD_SELECT, MODE_LONG,  st(MODE_LONG, 900, 900, 1, 0, 0, 0));
		lit_row(CMD_SELECT, MODE_SHORT, st(MODE_SHORT, 300, 300, 1, 0, 0, 0));
		lit_row(CMD_SKIP,   MODE_FOCUS, st(MODE_FOCUS, 1500, 1500, 1, 0, 1, 0));
		// Top lengths, long_every above MAX_BLOCKS, auto start: extend saturates.
		cfg_row(SEC_MAX, SEC_MAX, SEC_MAX, 4'hF, 1'b1);
		lit_row(CMD_SELECT, MODE_SHORT, st(MODE_SHORT, 65535, 65535, 1, 0, 0, 0));
		lit_row(CMD_EXTEND, MODE_FOCUS, st(MODE_SHORT, 65535, 65535, 1, 0, 0, 0));
		lit_row(CMD_SKIP,   MODE_FOCUS, st(MODE_FOCUS, 65535, 65535, 1, 1, 1, 0));
		lit_row(CMD_EXTEND, MODE_FOCUS, st(MODE_FOCUS, 65535, 65535, 1, 1, 0, 0));
		lit_row(CMD_SKIP,   MODE_FOCUS, st(MODE_SHORT, 65535, 65535, 2, 1, 1, 0));
		// Zero lengths rise to the minimum; long_every 0 acts as 1 and trims the count.
		cfg_row('0, '0, '0, '0, 1'b0);
		lit_row(CMD_SELECT, MODE_FOCUS, st(MODE_FOCUS, 60, 60, 0, 0, 0, 0));
		lit_row(CMD_SKIP,   MODE_FOCUS, st(MODE_LONG, 60, 60, 0, 0, 1, 1));
		lit_row(CMD_SKIP,   MODE_FOCUS, st(MODE_FOCUS, 60, 60, 0, 0, 1, 0));
		lit_row(CMD_TOGGLE, MODE_FOCUS, st(MODE_FOCUS, 60, 60, 0, 1, 0, 0));
		// reset while running keeps the run flag
		lit_row(CMD_RESET,  MODE_FOCUS, st(MODE_FOCUS, 60, 60, 0, 1, 0, 0));
		step_row(CMD_TICK, MODE_SHORT);
	endfunction

	// ---------------------------------------------------------------- driving

	// Random sender idling: each idle cycle is drawn separately.
	task automatic idle_gap();
		if ($urandom_range(99) < gap_pct) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
	endtask

	// Offers one command beat, waits for it to be taken, then records what it should
	// produce. The prediction always runs so the state stays in step; a literal row
	// replaces only the stored expectation.
	task automatic send(logic [CMD_W-1:0] c, logic [MODE_W-1:0] s, bit use_lit = 1'b0,
			timer_result_t lit = '0);
		timer_result_t r;
		idle_gap();
		cmd_ch.valid    <= 1'b1;
		cmd_ch.cmd      <= c;
		cmd_ch.mode_sel <= s;
		do @(posedge clk); while (!cmd_ch.ready);
		r = next_status(c, s);
		status_q.push_back(use_lit ? lit : r);
	endtask

	task automatic tick_run(int n);
		repeat (n) send(CMD_TICK, MODE_W'($urandom_range(3)));
	endtask

	// Sender stops and waits until every expected status beat has come back.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_WORK_SECS:  cfg_now.work_secs  = data;
			REG_SHORT_SECS: cfg_now.short_secs = data;
			REG_LONG_SECS:  cfg_now.long_secs  = data;
			REG_LONG_EVERY: cfg_now.long_every = data[EVCFG_W-1:0];
			REG_AUTO_START: cfg_now.auto_start = data[0];
			default: ;
		endcase
	endtask

	// Registers change only with the block idle.
	task automatic set_config(timer_cfg_t c);
		drain();
		write_reg(REG_WORK_SECS,  c.work_secs);
		write_reg(REG_SHORT_SECS, c.short_secs);
		write_reg(REG_LONG_SECS,  c.long_secs);
		write_reg(REG_LONG_EVERY, CFG_DATA_W'(c.long_every));
		write_reg(REG_AUTO_START, CFG_DATA_W'(c.auto_start));
		cfg_we <= 1'b0;
	endtask

	// 0: no idling, 1: sender idles, 2: receiver stalls, 3: both.
	task automatic set_idle(int mode);
		case (mode)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 86; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 86; end
			default: begin gap_pct = 31; stall_pct = 31; end
		endcase
	endtask

	function automatic logic [SEC_W-1:0] pick_len();
		case ($urandom_range(7))
			0: return '0;
			1: return MIN_PHASE - 1'b1;
			2: return MIN_PHASE;
			3: return SEC_MAX;
			4: return SEC_MAX - EXTEND_SECS;
			5, 6: return SEC_W'($urandom_range(61, 400));
			default: return SEC_W'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 48) return CMD_TICK;
		if (r < 60) return CMD_TOGGLE;
		if (r < 70) return CMD_SKIP;
		if (r < 78) return CMD_RESET;
		if (r < 86) return CMD_EXTEND;
		if (r < 97) return CMD_SELECT;
		return (r < 99) ? CMD_NOP6 : CMD_NOP7;
	endfunction

	// A second rolls over, a partial second is dropped by a pause, then skips under a
	// minute give no credit. Shortest lengths, no idling.
	task automatic run_tick_phase();
		set_config('{work_secs: '0, short_secs: '0, long_secs: '0, long_every: 4'd1,
			auto_start: 1'b1});
		set_idle(0);
		send(CMD_SELECT, MODE_SHORT);
		send(CMD_SELECT, MODE_FOCUS);
		send(CMD_TOGGLE, MODE_FOCUS);
		tick_run(1000);                   // one whole second counted off
		tick_run(200);                    // partial second
		send(CMD_TOGGLE, MODE_FOCUS);     // pause drops the partial second
		send(CMD_TOGGLE, MODE_FOCUS);
		send(CMD_EXTEND, MODE_FOCUS);
		send(CMD_SKIP, MODE_FOCUS);       // under a minute: no credit, long break runs
		send(CMD_SKIP, MODE_FOCUS);       // back to work, running
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		plan_row_t  row;
		timer_cfg_t c;
		int         p;
		int         k;
		cmd_ch.valid    <= 1'b0;
		cmd_ch.cmd      <= CMD_TICK;
		cmd_ch.mode_sel <= MODE_FOCUS;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_WORK_SECS;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		// Predictor starts from the reset state.
		cfg_now = '{work_secs: 16'd1500, short_secs: 16'd300, long_secs: 16'd900,
			long_every: 4'd4, auto_start: 1'b0};
		p_mode = MODE_FOCUS;
		p_secs = 16'd1500;
		p_len  = 16'd1500;
		p_ms   = '0;
		p_cnt  = '0;
		p_run  = 1'b0;
		build_plan();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table.
		set_idle(0);
		foreach (plan_q[i]) begin
			row = plan_q[i];
			if (row.is_cfg) set_config(row.cfg);
			else send(row.cmd, row.sel, row.has_lit, row.lit);
		end

		run_tick_phase();

		// Random phases, each with its own register setting and idling pattern.
		for (p = 0; p < RAND_PHASES; p++) begin
			if (p == 0) c = '{work_secs: SEC_MAX, short_secs: SEC_MAX, long_secs: SEC_MAX,
				long_every: 4'hF, auto_start: 1'b1};
			else if (p == 1) c = '{work_secs: '0, short_secs: '0, long_secs: '0,
				long_every: '0, auto_start: 1'b0};
			else c = '{work_secs: pick_len(), short_secs: pick_len(), long_secs: pick_len(),
				long_every: EVCFG_W'($urandom_range(15)), auto_start: 1'($urandom_range(1))};
			set_config(c);
			set_idle(p % 4);
			// Long receiver hold-off while the sender keeps offering beats.
			if (p == 4) hold_req = 1'b1;
			for (k = 0; k < RAND_PER_PHS; k++) begin
				send(pick_cmd(), MODE_W'($urandom_range(3)));
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (bad == 0 && status_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// ---------------------------------------------------------------- receiver

	initial begin
		status_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				status_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			status_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------- checking

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			bad++;
		end
	endfunction

	// Each status beat taken is compared with the oldest expectation.
	always @(posedge clk) begin : status_check
		timer_result_t e;
		if (arst_n && status_ch.valid && status_ch.ready) begin
			if (status_q.size() == 0) begin
				$error("status beat with no expected value");
				bad++;
			end else begin
				e = status_q.pop_front();
				check_field("phase_mode",      e.phase_mode,      status_ch.phase_mode);
				check_field("seconds_left",    e.seconds_left,    status_ch.seconds_left);
				check_field("phase_length",    e.phase_length,    status_ch.phase_length);
				check_field("blocks_in_cycle", e.blocks_in_cycle, status_ch.blocks_in_cycle);
				check_field("is_running",      e.is_running,      status_ch.is_running);
				check_field("phase_ended",     e.phase_ended,     status_ch.phase_ended);
				check_field("block_completed", e.block_completed, status_ch.block_completed);
				check_field("focus_credit",    e.focus_credit,    status_ch.focus_credit);
				check_field("went_long",       e.went_long,       status_ch.went_long);
			end
		end
	end

	// Hang watchdog: cycles in a row with no beat on either channel.
	always @(posedge clk) begin : hang_watch
		int quiet;
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) ||
				(status_ch.valid && status_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= HANG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

endmodule

@@ pomodoro_phase_timer_top.f @@
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_item_if.sv
rtl/ppt_result_if.sv
rtl/ppt_step.sv
rtl/pomodoro_phase_timer_top.sv
tb/tb.sv
